[hw/rtl/vrtm_pkg.sv]
// ----------------------------------------------------------------------------
// vrtm_pkg
// Shared constants, register codes and types of the rectangle transfer core.
// ----------------------------------------------------------------------------
`default_nettype none

package vrtm_pkg;

    localparam int STORE_WIDTH_DEF  = 1024;
    localparam int STORE_HEIGHT_DEF = 512;
    localparam int QUEUE_DEPTH      = 4;

    localparam int PIXEL_W       = 16;
    localparam int RECT_X_W      = 10;
    localparam int RECT_Y_W      = 9;
    localparam int RECT_WIDTH_W  = 11;
    localparam int RECT_HEIGHT_W = 10;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 11;

    localparam logic [PIXEL_W-1:0] MASK_BIT = 16'h8000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RECT_X      = 3'd0,
        REG_RECT_Y      = 3'd1,
        REG_RECT_WIDTH  = 3'd2,
        REG_RECT_HEIGHT = 3'd3,
        REG_MASK_CHECK  = 3'd4,
        REG_FORCE_MASK  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic mask_check;
        logic force_mask;
    } wr_mode_t;

endpackage

`default_nettype wire

[hw/rtl/vrtm_ram.sv]
// ----------------------------------------------------------------------------
// vrtm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vrtm_ram #(
    parameter int WIDTH = vrtm_pkg::PIXEL_W,
    parameter int DEPTH = vrtm_pkg::STORE_WIDTH_DEF * vrtm_pkg::STORE_HEIGHT_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/vrtm_fifo.sv]
// ----------------------------------------------------------------------------
// vrtm_fifo
// Small register queue with first-word fall-through output.
// ----------------------------------------------------------------------------
`default_nettype none

module vrtm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = vrtm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vrtm_front.sv]
// ----------------------------------------------------------------------------
// vrtm_front
// Configuration registers, rectangle walk and item intake.
// ----------------------------------------------------------------------------
`default_nettype none

module vrtm_front #(
    parameter int STORE_WIDTH  = vrtm_pkg::STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = vrtm_pkg::STORE_HEIGHT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic                                   op,
    input  logic [vrtm_pkg::PIXEL_W-1:0]           pixel_in,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vrtm_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [vrtm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   mid_full,
    input  logic                                   clearing,
    output logic                                   item_push,
    output logic [$clog2(STORE_WIDTH)+$clog2(STORE_HEIGHT)-1:0] item_addr,
    output logic                                   item_op,
    output logic [vrtm_pkg::PIXEL_W-1:0]           item_pixel,
    output logic                                   item_last,
    output vrtm_pkg::wr_mode_t                     wr_mode
);

    import vrtm_pkg::*;

    localparam int CW = $clog2(STORE_WIDTH);
    localparam int RW = $clog2(STORE_HEIGHT);
    localparam logic [CW-1:0] COL_MAX = CW'(STORE_WIDTH - 1);
    localparam logic [RW-1:0] ROW_MAX = RW'(STORE_HEIGHT - 1);

    // Remainder of a narrow value by a store dimension of at least 64.
    function automatic logic [15:0] wrap_mod(input logic [15:0] v, input logic [15:0] m);
        logic [15:0] r;
        r = v;
        for (int k = 3; k >= 0; k--)
        begin
            if (r >= (m << k))
            begin
                r = r - (m << k);
            end
        end
        return r;
    endfunction

    logic [RECT_X_W-1:0]      rect_x_reg;
    logic [RECT_Y_W-1:0]      rect_y_reg;
    logic [RECT_WIDTH_W-1:0]  rect_width_reg;
    logic [RECT_HEIGHT_W-1:0] rect_height_reg;
    logic                     mask_check_reg;
    logic                     force_mask_reg;

    logic [RECT_WIDTH_W-1:0]  col_off_reg, col_off_next;
    logic [RECT_HEIGHT_W-1:0] row_off_reg, row_off_next;
    logic [CW-1:0]            col_addr_reg, col_addr_next;
    logic [RW-1:0]            row_addr_reg, row_addr_next;
    logic                     origin_reg, origin_next;

    logic [CW-1:0]            col_base;
    logic [RW-1:0]            row_base;
    logic [CW-1:0]            cur_col;
    logic [RW-1:0]            cur_row;
    logic [RECT_WIDTH_W-1:0]  width_m1;
    logic [RECT_HEIGHT_W-1:0] height_m1;
    logic                     row_end;
    logic                     last;
    logic                     accept;
    logic                     cfg_write;
    logic                     restart;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign full      = clearing || mid_full;
    assign accept    = push && !full;

    assign col_base = CW'(wrap_mod(16'(rect_x_reg), 16'(STORE_WIDTH)));
    assign row_base = ROW_MAX - RW'(wrap_mod(16'(rect_y_reg), 16'(STORE_HEIGHT)));
    assign cur_col  = origin_reg ? col_base : col_addr_reg;
    assign cur_row  = origin_reg ? row_base : row_addr_reg;

    assign width_m1  = (rect_width_reg == '0) ? '0 : rect_width_reg - 1'b1;
    assign height_m1 = (rect_height_reg == '0) ? '0 : rect_height_reg - 1'b1;
    assign row_end   = (col_off_reg >= width_m1);
    assign last      = row_end && (row_off_reg >= height_m1);

    assign item_push  = accept;
    assign item_addr  = {cur_row, cur_col};
    assign item_op    = op;
    assign item_pixel = pixel_in;
    assign item_last  = last;

    assign wr_mode.mask_check = mask_check_reg;
    assign wr_mode.force_mask = force_mask_reg;

    always_comb
    begin
        restart = 1'b0;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RECT_X, REG_RECT_Y, REG_RECT_WIDTH, REG_RECT_HEIGHT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        col_off_next  = col_off_reg;
        row_off_next  = row_off_reg;
        col_addr_next = col_addr_reg;
        row_addr_next = row_addr_reg;
        origin_next   = origin_reg;
        if (restart)
        begin
            col_off_next = '0;
            row_off_next = '0;
            origin_next  = 1'b1;
        end
        else if (accept)
        begin
            if (last)
            begin
                col_off_next = '0;
                row_off_next = '0;
                origin_next  = 1'b1;
            end
            else if (row_end)
            begin
                col_off_next  = '0;
                row_off_next  = row_off_reg + 1'b1;
                col_addr_next = col_base;
                row_addr_next = (cur_row == '0) ? ROW_MAX : cur_row - 1'b1;
                origin_next   = 1'b0;
            end
            else
            begin
                col_off_next  = col_off_reg + 1'b1;
                col_addr_next = (cur_col == COL_MAX) ? '0 : cur_col + 1'b1;
                row_addr_next = cur_row;
                origin_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_x_reg      <= '0;
            rect_y_reg      <= '0;
            rect_width_reg  <= RECT_WIDTH_W'(1);
            rect_height_reg <= RECT_HEIGHT_W'(1);
            mask_check_reg  <= 1'b0;
            force_mask_reg  <= 1'b0;
            col_off_reg     <= '0;
            row_off_reg     <= '0;
            col_addr_reg    <= '0;
            row_addr_reg    <= '0;
            origin_reg      <= 1'b1;
        end
        else
        begin
            col_off_reg  <= col_off_next;
            row_off_reg  <= row_off_next;
            col_addr_reg <= col_addr_next;
            row_addr_reg <= row_addr_next;
            origin_reg   <= origin_next;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RECT_X:      rect_x_reg      <= cfg_data[RECT_X_W-1:0];
                    REG_RECT_Y:      rect_y_reg      <= cfg_data[RECT_Y_W-1:0];
                    REG_RECT_WIDTH:  rect_width_reg  <= cfg_data[RECT_WIDTH_W-1:0];
                    REG_RECT_HEIGHT: rect_height_reg <= cfg_data[RECT_HEIGHT_W-1:0];
                    REG_MASK_CHECK:  mask_check_reg  <= cfg_data[0];
                    REG_FORCE_MASK:  force_mask_reg  <= cfg_data[0];
                    default:         mask_check_reg  <= mask_check_reg;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vrtm_back.sv]
// ----------------------------------------------------------------------------
// vrtm_back
// Pixel store with clearing sweep and pipelined read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none

module vrtm_back #(
    parameter int STORE_WIDTH  = vrtm_pkg::STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = vrtm_pkg::STORE_HEIGHT_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_empty,
    output logic                                   item_pop,
    input  logic [$clog2(STORE_WIDTH)+$clog2(STORE_HEIGHT)-1:0] item_addr,
    input  logic                                   item_op,
    input  logic [vrtm_pkg::PIXEL_W-1:0]           item_pixel,
    input  logic                                   item_last,
    input  vrtm_pkg::wr_mode_t                     wr_mode,
    output logic                                   clearing,
    input  logic                                   res_full,
    output logic                                   res_push,
    output logic [vrtm_pkg::PIXEL_W-1:0]           res_read_data,
    output logic                                   res_write_skipped,
    output logic                                   res_last
);

    import vrtm_pkg::*;

    localparam int AW = $clog2(STORE_WIDTH) + $clog2(STORE_HEIGHT);
    localparam int DEPTH = 1 << AW;

    logic              clr_active_reg;
    logic [AW-1:0]     clr_addr_reg;

    logic              s2_valid_reg;
    logic [AW-1:0]     s2_addr_reg;
    logic              s2_op_reg;
    logic [PIXEL_W-1:0] s2_pixel_reg;
    logic              s2_last_reg;

    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [PIXEL_W-1:0] fwd_data_reg;

    logic              adv;
    logic [PIXEL_W-1:0] ram_rdata;
    logic [PIXEL_W-1:0] old_pixel;
    logic [PIXEL_W-1:0] new_pixel;
    logic              skip;
    logic              wr_fire;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;

    assign clearing = clr_active_reg;
    assign adv      = !s2_valid_reg || !res_full;
    assign item_pop = adv && !item_empty && !clr_active_reg;

    assign old_pixel = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                         : ram_rdata;
    assign skip      = !s2_op_reg && wr_mode.mask_check && ((old_pixel & MASK_BIT) != '0);
    assign new_pixel = wr_mode.force_mask ? (s2_pixel_reg | MASK_BIT) : s2_pixel_reg;
    assign wr_fire   = s2_valid_reg && adv && !s2_op_reg && !skip;

    assign ram_we    = clr_active_reg || wr_fire;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s2_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : new_pixel;

    assign res_push          = s2_valid_reg && adv;
    assign res_read_data     = s2_op_reg ? old_pixel : '0;
    assign res_write_skipped = skip;
    assign res_last          = s2_last_reg;

    vrtm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (item_pop),
        .raddr (item_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            s2_addr_reg  <= item_addr;
            s2_op_reg    <= item_op;
            s2_pixel_reg <= item_pixel;
            s2_last_reg  <= item_last;
        end
        if (adv)
        begin
            fwd_addr_reg <= s2_addr_reg;
            fwd_data_reg <= new_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s2_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (adv)
            begin
                s2_valid_reg  <= item_pop;
                fwd_valid_reg <= wr_fire;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/vram_rect_transfer_masked_core.sv]
// ----------------------------------------------------------------------------
// vram_rect_transfer_masked_core
// Rectangle pixel transfer into and out of a masked 16-bit pixel store.
// ----------------------------------------------------------------------------
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  input     | push / full          | op, pixel_in
//  result    | pop / empty          | read_data, write_skipped, last_pixel
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One item per cycle sustained while results are popped; a result reaches the
//  result ports through the item queue, the registered store read ahead of the
//  read-modify-write stage and the result queue. After reset a sweep zeroes
//  the store, one word a cycle, over 2**(clog2(STORE_WIDTH)+clog2(STORE_HEIGHT))
//  words (524288 at the default size); full stays high meanwhile. A stalled
//  result side fills the four-entry result queue, the read-modify-write stage
//  and the four-entry item queue, then raises full.
// ----------------------------------------------------------------------------
`default_nettype none

module vram_rect_transfer_masked_core #(
    parameter int STORE_WIDTH  = vrtm_pkg::STORE_WIDTH_DEF,
    parameter int STORE_HEIGHT = vrtm_pkg::STORE_HEIGHT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             op,
    input  logic [vrtm_pkg::PIXEL_W-1:0]     pixel_in,
    output logic                             empty,
    input  logic                             pop,
    output logic [vrtm_pkg::PIXEL_W-1:0]     read_data,
    output logic                             write_skipped,
    output logic                             last_pixel,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vrtm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [vrtm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import vrtm_pkg::*;

    localparam int AW = $clog2(STORE_WIDTH) + $clog2(STORE_HEIGHT);
    localparam int MID_W = AW + 1 + PIXEL_W + 1;
    localparam int RES_W = PIXEL_W + 2;

    logic               mid_push;
    logic               mid_full;
    logic               mid_pop;
    logic               mid_empty;
    logic [MID_W-1:0]   mid_din;
    logic [MID_W-1:0]   mid_dout;
    logic [AW-1:0]      fr_addr;
    logic               fr_op;
    logic [PIXEL_W-1:0] fr_pixel;
    logic               fr_last;
    logic [AW-1:0]      bk_addr;
    logic               bk_op;
    logic [PIXEL_W-1:0] bk_pixel;
    logic               bk_last;
    wr_mode_t           wr_mode;
    logic               clearing;
    logic               res_push;
    logic               res_full;
    logic [PIXEL_W-1:0] res_read_data;
    logic               res_write_skipped;
    logic               res_last;
    logic [RES_W-1:0]   res_din;
    logic [RES_W-1:0]   res_dout;

    vrtm_front #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .op         (op),
        .pixel_in   (pixel_in),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mid_full   (mid_full),
        .clearing   (clearing),
        .item_push  (mid_push),
        .item_addr  (fr_addr),
        .item_op    (fr_op),
        .item_pixel (fr_pixel),
        .item_last  (fr_last),
        .wr_mode    (wr_mode)
    );

    assign mid_din = {fr_addr, fr_op, fr_pixel, fr_last};
    assign {bk_addr, bk_op, bk_pixel, bk_last} = mid_dout;

    vrtm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_din),
        .full  (mid_full),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    vrtm_back #(
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_HEIGHT (STORE_HEIGHT)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_empty        (mid_empty),
        .item_pop          (mid_pop),
        .item_addr         (bk_addr),
        .item_op           (bk_op),
        .item_pixel        (bk_pixel),
        .item_last         (bk_last),
        .wr_mode           (wr_mode),
        .clearing          (clearing),
        .res_full          (res_full),
        .res_push          (res_push),
        .res_read_data     (res_read_data),
        .res_write_skipped (res_write_skipped),
        .res_last          (res_last)
    );

    assign res_din = {res_read_data, res_write_skipped, res_last};
    assign {read_data, write_skipped, last_pixel} = res_dout;

    vrtm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res_din),
        .full  (res_full),
        .pop   (pop),
        .dout  (res_dout),
        .empty (empty)
    );

endmodule

`default_nettype wire

[hw/rtl/vrtm_checker.sv]
// ----------------------------------------------------------------------------
// vrtm_checker
// Port-level checks of the rectangle transfer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vrtm_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  logic                         full,
    input  logic                         empty,
    input  logic                         pop,
    input  logic [vrtm_pkg::PIXEL_W-1:0] read_data,
    input  logic                         write_skipped,
    input  logic                         last_pixel
);

    logic [5:0] pending_reg;
    logic       in_take;
    logic       out_take;

    assign in_take  = push && !full;
    assign out_take = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pending_reg <= pending_reg + 1'b1;
        end
        else if (out_take && !in_take)
        begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    a_clear_holds_off: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> full && empty)
        else $error("item intake open right after reset");

    a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != '0)
        else $error("result shown with no item outstanding");

    a_skip_has_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && write_skipped) |-> read_data == '0)
        else $error("skipped write carries read data");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty && $stable(read_data) && $stable(write_skipped)
                             && $stable(last_pixel))
        else $error("waiting result changed");

endmodule

bind vram_rect_transfer_masked_core vrtm_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .empty         (empty),
    .pop           (pop),
    .read_data     (read_data),
    .write_skipped (write_skipped),
    .last_pixel    (last_pixel)
);

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked rectangle pixel transfer core. A driver
// streams pixel items from a queue, a scoreboard mirror of the pixel store
// predicts every result, and a monitor compares results as they are popped.
// Register settings change between phases while the core is idle.
// ----------------------------------------------------------------------------
module testbench;

    import vrtm_pkg::*;

    localparam int STORE_W = STORE_WIDTH_DEF;
    localparam int STORE_H = STORE_HEIGHT_DEF;
    localparam int IDLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 360;
    localparam int TALL_ITEMS = 520;
    localparam int TAIL_ITEMS = 60;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct packed {
        logic op;
        logic [PIXEL_W-1:0] pix;
    } pixel_item_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] data;
        logic skipped;
        logic last;
    } pixel_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic op = OP_WRITE;
    logic [PIXEL_W-1:0] pixel_in = '0;
    logic empty;
    logic pop = 1'b0;
    logic [PIXEL_W-1:0] read_data;
    logic write_skipped;
    logic last_pixel;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // store mirror and walk state
    bit [PIXEL_W-1:0] pixel_mirror [0:STORE_W*STORE_H-1];
    logic [RECT_X_W-1:0] rect_x_q = '0;
    logic [RECT_Y_W-1:0] rect_y_q = '0;
    logic [RECT_WIDTH_W-1:0] rect_w_q = 11'd1;
    logic [RECT_HEIGHT_W-1:0] rect_h_q = 10'd1;
    logic mask_check_q = 1'b0;
    logic force_mask_q = 1'b0;
    logic [RECT_WIDTH_W-1:0] col_ofs = '0;
    logic [RECT_HEIGHT_W-1:0] row_ofs = '0;

    pixel_item_t pending_items[$];
    pixel_result_t pixel_results[$];

    int err_count = 0;
    bit quiet_tail = 1'b0;
    bit send_taken;
    int send_gap = 0;
    int send_calm = 0;
    int recv_hold = 0;
    int recv_calm = 0;
    int long_holds = 0;
    int idle_cycles = 0;

    vram_rect_transfer_masked_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .op            (op),
        .pixel_in      (pixel_in),
        .empty         (empty),
        .pop           (pop),
        .read_data     (read_data),
        .write_skipped (write_skipped),
        .last_pixel    (last_pixel),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic pixel_result_t transfer_pixel(input logic rd,
                                                     input logic [PIXEL_W-1:0] pix);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        int unsigned addr;
        logic row_end;
        logic at_last;
        pixel_result_t res;
        w = (rect_w_q == 0) ? 1 : int'(rect_w_q);
        h = (rect_h_q == 0) ? 1 : int'(rect_h_q);
        col = (int'(rect_x_q) + int'(col_ofs)) % STORE_W;
        row = (STORE_H - 1 + 2 * STORE_H - (int'(rect_y_q) % STORE_H)
               - (int'(row_ofs) % STORE_H)) % STORE_H;
        addr = row * STORE_W + col;
        row_end = (int'(col_ofs) >= w - 1);
        at_last = row_end && (int'(row_ofs) >= h - 1);
        res = '0;
        if (rd == OP_READ)
            res.data = pixel_mirror[addr];
        else if (mask_check_q && (pixel_mirror[addr] & MASK_BIT) != 0)
            res.skipped = 1'b1;
        else
            pixel_mirror[addr] = force_mask_q ? (pix | MASK_BIT) : pix;
        res.last = at_last;
        if (at_last)
        begin
            col_ofs = '0;
            row_ofs = '0;
        end
        else if (row_end)
        begin
            col_ofs = '0;
            row_ofs = row_ofs + 1'b1;
        end
        else
        begin
            col_ofs = col_ofs + 1'b1;
        end
        return res;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            send_taken = push && !full;
            if (send_taken)
            begin
                pixel_results.push_back(transfer_pixel(op, pixel_in));
                void'(pending_items.pop_front());
            end
            if (!quiet_tail && send_gap == 0 && (send_taken || !push))
            begin
                if (send_calm > 0)
                    send_calm--;
                else
                begin
                    case ($urandom_range(0, 31))
                        0, 1, 2, 3: send_gap = $urandom_range(1, 16);
                        4: send_calm = $urandom_range(40, 120);
                        default: ;
                    endcase
                end
            end
            if (send_gap > 0 && !quiet_tail)
            begin
                send_gap--;
                push <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                push <= 1'b1;
                op <= pending_items[0].op;
                pixel_in <= pending_items[0].pix;
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (pixel_results.size() == 0)
                begin
                    $error("result popped with nothing expected");
                    err_count++;
                end
                else
                begin
                    if (read_data !== pixel_results[0].data)
                    begin
                        $error("read_data: expected %h, got %h", pixel_results[0].data, read_data);
                        err_count++;
                    end
                    if (write_skipped !== pixel_results[0].skipped)
                    begin
                        $error("write_skipped: expected %b, got %b",
                               pixel_results[0].skipped, write_skipped);
                        err_count++;
                    end
                    if (last_pixel !== pixel_results[0].last)
                    begin
                        $error("last_pixel: expected %b, got %b", pixel_results[0].last, last_pixel);
                        err_count++;
                    end
                    void'(pixel_results.pop_front());
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                pop <= 1'b0;
            end
            else if (long_holds < 3 && pending_items.size() > 24)
            begin
                long_holds++;
                recv_hold = 59;
                pop <= 1'b0;
            end
            else if (quiet_tail || recv_calm > 0)
            begin
                if (recv_calm > 0)
                    recv_calm--;
                pop <= 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 31))
                    0, 1, 2, 3:
                    begin
                        recv_hold = $urandom_range(0, 15);
                        pop <= 1'b0;
                    end
                    4:
                    begin
                        recv_calm = $urandom_range(40, 120);
                        pop <= 1'b1;
                    end
                    default: pop <= 1'b1;
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("** vram_rect_transfer_masked_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_RECT_X: rect_x_q = val[RECT_X_W-1:0];
            REG_RECT_Y: rect_y_q = val[RECT_Y_W-1:0];
            REG_RECT_WIDTH: rect_w_q = val[RECT_WIDTH_W-1:0];
            REG_RECT_HEIGHT: rect_h_q = val[RECT_HEIGHT_W-1:0];
            REG_MASK_CHECK: mask_check_q = val[0];
            REG_FORCE_MASK: force_mask_q = val[0];
            default: ;
        endcase
        if (idx == REG_RECT_X || idx == REG_RECT_Y || idx == REG_RECT_WIDTH
            || idx == REG_RECT_HEIGHT)
        begin
            col_ofs = '0;
            row_ofs = '0;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic write_rect(input int unsigned x, input int unsigned y,
                              input int unsigned w, input int unsigned h);
        write_reg(REG_RECT_X, x);
        write_reg(REG_RECT_Y, y);
        write_reg(REG_RECT_WIDTH, w);
        write_reg(REG_RECT_HEIGHT, h);
    endtask

    task automatic add_item(input logic rd, input logic [PIXEL_W-1:0] pix);
        pixel_item_t it;
        it.op = rd;
        it.pix = pix;
        pending_items.push_back(it);
    endtask

    task automatic fill_phase(input int count);
        @(negedge clk);
        repeat (count)
            add_item(($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE, PIXEL_W'($urandom));
    endtask

    // hold off until the core has returned every expected result
    task automatic drain_results();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || push || pixel_results.size() != 0);
    endtask

    initial
    begin
        int sent;
        int n;
        int unsigned w;
        int unsigned h;
        int unsigned area;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // one-pixel rectangle at reset settings
        @(negedge clk);
        add_item(OP_WRITE, 16'hFFFF);
        add_item(OP_READ, 16'h0000);
        add_item(OP_WRITE, 16'h0000);
        add_item(OP_READ, 16'hFFFF);
        drain_results();

        // corner rectangle wrapping both axes, mask check on
        write_rect(1023, 511, 2, 2);
        write_reg(REG_MASK_CHECK, 1);
        @(negedge clk);
        add_item(OP_WRITE, 16'h8000);
        add_item(OP_WRITE, 16'h7FFF);
        add_item(OP_WRITE, 16'h0001);
        add_item(OP_WRITE, 16'hFFFF);
        repeat (4) add_item(OP_WRITE, 16'h1234);
        repeat (4) add_item(OP_READ, 16'h0000);
        drain_results();

        // zero sizes act as one, force mask, spare register indexes
        write_reg(REG_RECT_WIDTH, 0);
        write_reg(REG_RECT_HEIGHT, 0);
        write_reg(REG_MASK_CHECK, 0);
        write_reg(REG_FORCE_MASK, 1);
        write_reg(REG_SPARE_6, 32'h7FF);
        write_reg(REG_SPARE_7, 32'h7FF);
        @(negedge clk);
        add_item(OP_WRITE, 16'h0001);
        add_item(OP_READ, 16'h0000);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_MASK_CHECK, $urandom_range(0, 1));
                write_reg(REG_FORCE_MASK, $urandom_range(0, 1));
                n = $urandom_range(4, 40);
            end
            else
            begin
                case ($urandom_range(0, 15))
                    0: w = 0;
                    1: w = 2047;
                    2: w = 1024;
                    default: w = $urandom_range(1, 8);
                endcase
                case ($urandom_range(0, 15))
                    0: h = 0;
                    1: h = 1023;
                    2: h = 512;
                    default: h = $urandom_range(1, 6);
                endcase
                write_rect($urandom_range(0, 2047), $urandom_range(0, 2047), w, h);
                write_reg(REG_MASK_CHECK, $urandom_range(0, 1));
                write_reg(REG_FORCE_MASK, $urandom_range(0, 1));
                if ($urandom_range(0, 7) == 0)
                    write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_6, REG_SPARE_7)), $urandom);
                area = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
                if (area <= 48)
                    n = area * $urandom_range(1, 3) + $urandom_range(0, area - 1);
                else
                    n = $urandom_range(8, 30);
            end
            fill_phase(n);
            sent += n;
            drain_results();
        end

        // rows wrap past the bottom of the store and revisit the first rows
        write_rect($urandom_range(0, 1023), $urandom_range(0, 511), 1, 514);
        write_reg(REG_MASK_CHECK, 1);
        write_reg(REG_FORCE_MASK, 0);
        fill_phase(TALL_ITEMS);
        drain_results();

        quiet_tail = 1'b1;
        write_rect($urandom_range(0, 1023), $urandom_range(0, 511), 5, 4);
        write_reg(REG_MASK_CHECK, $urandom_range(0, 1));
        fill_phase(TAIL_ITEMS);
        drain_results();

        repeat (8) @(posedge clk);
        if (err_count == 0 && pixel_results.size() == 0)
            $display("** vram_rect_transfer_masked_core: PASSED **");
        else
            $display("** vram_rect_transfer_masked_core: FAILED **");
        $finish;
    end

endmodule
